FILE: hdl/mmss_clock_with_display_scan_macros.svh
// Assertion macros shared by the clock display block.
`ifndef MMSS_CLOCK_WITH_DISPLAY_SCAN_MACROS_SVH
`define MMSS_CLOCK_WITH_DISPLAY_SCAN_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define MMSS_ASSERT_IMPLIES(label, clock, resetn, cond, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (cond) |-> (cons)) \
        else $error(msg);

// Check that a condition implies something of the next cycle.
`define MMSS_ASSERT_NEXT(label, clock, resetn, cond, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (cond) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/mmss_pkg.sv
// Package: types, codes and lookup functions of the clock display block.
`default_nettype none

package mmss_pkg;

    // Item command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_KEYS = 1'b1;

    // Register indexes on the configuration port (paddr[3:2])
    localparam logic [1:0] REG_COMMON_CATHODE   = 2'd0;
    localparam logic [1:0] REG_TICKS_PER_SECOND = 2'd1;
    localparam logic [1:0] REG_BLINK_PERIOD     = 2'd2;

    localparam int unsigned PADDR_W = 4;

    // Reset values
    localparam logic [15:0] TICKS_PER_SECOND_RST = 16'd1000;
    localparam logic [15:0] BLINK_PERIOD_RST     = 16'd250;
    localparam logic [4:0]  HOUR_RST             = 5'd12;
    localparam logic [5:0]  MINUTE_RST           = 6'd12;

    localparam logic [5:0] MAX_MIN_SEC = 6'd59;
    localparam logic [4:0] MAX_HOUR    = 5'd23;

    typedef enum logic [1:0] {
        MODE_RUN     = 2'd0,
        MODE_SET_MIN = 2'd1,
        MODE_SET_SEC = 2'd2
    } mode_t;

    typedef struct packed {
        logic command;
        logic key_mode_level;
        logic key_add_level;
        logic key_sub_level;
        logic key_ok_level;
    } item_t;

    typedef struct packed {
        logic [7:0] segment_pins;
        logic [3:0] digit_select;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [1:0] edit_mode;
    } result_t;

    typedef struct packed {
        logic        common_cathode;
        logic [15:0] ticks_per_second;
        logic [15:0] blink_period;
    } cfg_t;

    // Tens digit of a value below 64
    function automatic logic [3:0] tens_digit(input logic [5:0] v);
        logic [3:0] t;
        if (v >= 6'd60)      t = 4'd6;
        else if (v >= 6'd50) t = 4'd5;
        else if (v >= 6'd40) t = 4'd4;
        else if (v >= 6'd30) t = 4'd3;
        else if (v >= 6'd20) t = 4'd2;
        else if (v >= 6'd10) t = 4'd1;
        else                 t = 4'd0;
        return t;
    endfunction

    // Ones digit of a value below 64
    function automatic logic [3:0] ones_digit(input logic [5:0] v);
        logic [6:0] prod;
        logic [5:0] rem;
        prod = {3'd0, tens_digit(v)} * 7'd10;
        rem  = v - prod[5:0];
        return rem[3:0];
    endfunction

    // Segment code, bit 0 = A ... bit 6 = G, bit 7 = DP
    function automatic logic [7:0] seg_code(input logic cc, input logic [3:0] d);
        logic [7:0] c;
        case (d)
            4'd0:    c = 8'h3F;
            4'd1:    c = 8'h06;
            4'd2:    c = 8'h5B;
            4'd3:    c = 8'h4F;
            4'd4:    c = 8'h66;
            4'd5:    c = 8'h6D;
            4'd6:    c = 8'h7D;
            4'd7:    c = 8'h07;
            4'd8:    c = 8'h7F;
            default: c = 8'h6F;
        endcase
        // common anode codes are the complement
        return cc ? c : ~c;
    endfunction

    // Segment bits to port pins
    function automatic logic [7:0] remap_pins(input logic [7:0] c);
        logic [7:0] p;
        p[7] = c[0];
        p[5] = c[1];
        p[1] = c[2];
        p[3] = c[3];
        p[4] = c[4];
        p[6] = c[5];
        p[0] = c[6];
        p[2] = c[7];
        return p;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/mmss_cfg.sv
// Configuration register file behind the APB-style port.
`default_nettype none

module mmss_cfg
    import mmss_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.common_cathode   <= 1'b0;
            cfg_reg.ticks_per_second <= TICKS_PER_SECOND_RST;
            cfg_reg.blink_period     <= BLINK_PERIOD_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_COMMON_CATHODE:   cfg_reg.common_cathode   <= pwdata[0];
                REG_TICKS_PER_SECOND: cfg_reg.ticks_per_second <= pwdata[15:0];
                REG_BLINK_PERIOD:     cfg_reg.blink_period     <= pwdata[15:0];
                default:              ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_COMMON_CATHODE:   prdata = {31'd0, cfg_reg.common_cathode};
            REG_TICKS_PER_SECOND: prdata = {16'd0, cfg_reg.ticks_per_second};
            REG_BLINK_PERIOD:     prdata = {16'd0, cfg_reg.blink_period};
            default:              prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/mmss_core.sv
// Clock state, key handling and digit scan for one item per step.
`default_nettype none

module mmss_core
    import mmss_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    step,
    input  wire item_t   item,
    input  wire cfg_t    cfg,
    output result_t      result_next
);

    logic [4:0]  hour_reg,     hour_next;
    logic [5:0]  minute_reg,   minute_next;
    logic [5:0]  second_reg,   second_next;
    logic [15:0] tick_reg,     tick_next;
    logic [15:0] blink_reg,    blink_next;
    logic        visible_reg,  visible_next;
    mode_t       mode_reg,     mode_next;
    logic [1:0]  scan_reg,     scan_next;
    logic [3:0]  keys_reg,     keys_next;
    logic [7:0]  segs_reg,     segs_next;
    logic [3:0]  digits_reg,   digits_next;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hour_reg    <= HOUR_RST;
            minute_reg  <= MINUTE_RST;
            second_reg  <= 6'd0;
            tick_reg    <= 16'd0;
            blink_reg   <= 16'd0;
            visible_reg <= 1'b1;
            mode_reg    <= MODE_RUN;
            scan_reg    <= 2'd0;
            keys_reg    <= 4'hF;
            segs_reg    <= 8'hFF;
            digits_reg  <= 4'hF;
        end
        else if (step)
        begin
            hour_reg    <= hour_next;
            minute_reg  <= minute_next;
            second_reg  <= second_next;
            tick_reg    <= tick_next;
            blink_reg   <= blink_next;
            visible_reg <= visible_next;
            mode_reg    <= mode_next;
            scan_reg    <= scan_next;
            keys_reg    <= keys_next;
            segs_reg    <= segs_next;
            digits_reg  <= digits_next;
        end
    end

    // Next state for one item
    always_comb
    begin
        logic [5:0]  val;
        logic [3:0]  dig;
        logic [7:0]  code;
        logic        blank;
        logic [16:0] blink_inc;
        logic [16:0] tick_inc;
        logic [3:0]  now;
        logic [3:0]  fall;

        hour_next    = hour_reg;
        minute_next  = minute_reg;
        second_next  = second_reg;
        tick_next    = tick_reg;
        blink_next   = blink_reg;
        visible_next = visible_reg;
        mode_next    = mode_reg;
        scan_next    = scan_reg;
        keys_next    = keys_reg;
        segs_next    = segs_reg;
        digits_next  = digits_reg;

        val       = (scan_reg[1] == 1'b0) ? minute_reg : second_reg;
        dig       = scan_reg[0] ? ones_digit(val) : tens_digit(val);
        blink_inc = {1'b0, blink_reg} + 17'd1;
        tick_inc  = {1'b0, tick_reg} + 17'd1;
        now       = {item.key_ok_level, item.key_sub_level,
                     item.key_add_level, item.key_mode_level};
        fall      = keys_reg & ~now;
        code      = 8'h00;
        blank     = 1'b0;

        if (item.command == CMD_TICK)
        begin
            // scan one digit; point on digit one, then blanking
            code = seg_code(cfg.common_cathode, dig);
            if (scan_reg == 2'd1)
                code[7] = cfg.common_cathode;
            blank = ((mode_reg == MODE_SET_MIN) && !scan_reg[1]) ||
                    ((mode_reg == MODE_SET_SEC) && scan_reg[1]);
            if (blank && !visible_reg)
                code = cfg.common_cathode ? 8'h00 : 8'hFF;
            segs_next   = remap_pins(code);
            digits_next = ~(4'b1000 >> scan_reg);
            scan_next   = scan_reg + 2'd1;

            // blink phase
            if (blink_inc >= {1'b0, cfg.blink_period})
            begin
                blink_next   = 16'd0;
                visible_next = ~visible_reg;
            end
            else
                blink_next = blink_inc[15:0];

            // second counter and time of day
            if (tick_inc >= {1'b0, cfg.ticks_per_second})
            begin
                tick_next = 16'd0;
                if (second_reg >= MAX_MIN_SEC)
                begin
                    second_next = 6'd0;
                    if (minute_reg >= MAX_MIN_SEC)
                    begin
                        minute_next = 6'd0;
                        hour_next   = (hour_reg >= MAX_HOUR) ? 5'd0 : hour_reg + 5'd1;
                    end
                    else
                        minute_next = minute_reg + 6'd1;
                end
                else
                    second_next = second_reg + 6'd1;
            end
            else
                tick_next = tick_inc[15:0];
        end
        else
        begin
            // mode key first, so add and sub see the new mode
            if (fall[0])
            begin
                case (mode_reg)
                    MODE_RUN:     mode_next = MODE_SET_MIN;
                    MODE_SET_MIN: mode_next = MODE_SET_SEC;
                    default:      mode_next = MODE_RUN;
                endcase
                blink_next   = 16'd0;
                visible_next = 1'b1;
            end
            if (fall[1])
            begin
                if (mode_next == MODE_SET_MIN)
                    minute_next = (minute_next >= MAX_MIN_SEC) ? 6'd0 : minute_next + 6'd1;
                else if (mode_next == MODE_SET_SEC)
                    second_next = (second_next >= MAX_MIN_SEC) ? 6'd0 : second_next + 6'd1;
            end
            if (fall[2])
            begin
                if (mode_next == MODE_SET_MIN)
                    minute_next = (minute_next == 6'd0) ? MAX_MIN_SEC : minute_next - 6'd1;
                else if (mode_next == MODE_SET_SEC)
                    second_next = (second_next == 6'd0) ? MAX_MIN_SEC : second_next - 6'd1;
            end
            if (fall[3])
            begin
                second_next  = 6'd0;
                mode_next    = MODE_RUN;
                blink_next   = 16'd0;
                visible_next = 1'b1;
            end
            keys_next = now;
        end

        result_next.segment_pins = segs_next;
        result_next.digit_select = digits_next;
        result_next.hours        = hour_next;
        result_next.minutes      = minute_next;
        result_next.seconds      = second_next;
        result_next.edit_mode    = mode_next;
    end

endmodule

`default_nettype wire

FILE: hdl/mmss_clock_with_display_scan.sv
// Top level: item and result channels, pipeline registers, config port.
//
// Usage:
//   item channel (item_valid/item_ready/item) takes one beat per cycle unless the result channel stalls:
//   command 0 is a millisecond tick that scans the next display digit
//   and advances the blink and second counters; command 1 is a sample
//   of the four active-low key levels, acted on at falling edges.
//   Each item gives one beat on the result channel
//   (result_valid/result_ready/result): segment pins, digit select,
//   hours, minutes, seconds and edit mode after that item.
//   An accepted beat is loaded in the stage register, and its result is
//   loaded in the result register when the stage advances, that is when
//   the result register is free or being emptied. Throughput is one item
//   per cycle while the receiver does not stall, as the clock state is
//   updated combinationally between the stage and result registers.
//   When the receiver stalls, the result register holds; the stage holds
//   one more item, then item_ready drops until the result is taken.
//   Reset shows 12:12:00 in run mode, segments and digits off; the
//   registers come up as 0 (common anode), 1000 ticks per second and a
//   blink period of 250 ticks. Configure only while the block is idle.
`default_nettype none

module mmss_clock_with_display_scan
    import mmss_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire item_t              item,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output result_t                 result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

`include "mmss_clock_with_display_scan_macros.svh"

    cfg_t    cfg;
    item_t   stage_reg;
    logic    stage_valid_reg;
    logic    advance;
    result_t result_next;
    result_t result_reg;
    logic    result_valid_reg;

    mmss_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Stage moves on when the result register is free or being emptied
    assign advance    = stage_valid_reg & (~result_valid_reg | result_ready);
    assign item_ready = ~stage_valid_reg | advance;

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (item_ready)
            stage_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            stage_reg <= item;
    end

    mmss_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .item        (stage_reg),
        .cfg         (cfg),
        .result_next (result_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Checks
    `MMSS_ASSERT_IMPLIES(a_stall_only_when_full, clk, rst_n, !item_ready,
        result_valid_reg && !result_ready, "input stalled while result path is free")
    `MMSS_ASSERT_IMPLIES(a_one_digit_lit, clk, rst_n, result_valid_reg,
        ($countones(result_reg.digit_select) == 3) || (result_reg.digit_select == 4'hF),
        "more than one digit line driven")
    `MMSS_ASSERT_NEXT(a_result_from_stage, clk, rst_n, !stage_valid_reg && !result_valid_reg,
        !result_valid_reg, "result appeared without a staged item")
    `MMSS_ASSERT_IMPLIES(a_time_in_range, clk, rst_n, result_valid_reg,
        (result_reg.seconds <= MAX_MIN_SEC) && (result_reg.hours <= MAX_HOUR),
        "time value out of range")

endmodule

`default_nettype wire
